>>> sv/wnc_pkg.sv
// Shared types and constants for the weighted node choice block.
// Item structs, command/status structs and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wnc_pkg;

    localparam int SCORE_W  = 16;
    localparam int WEIGHT_W = 48;
    localparam int RAND_W   = 8;
    localparam int SKEW_W   = 16;
    localparam int CHOICE_W = 6;
    localparam int RULE_W   = 2;
    localparam int Q_FRAC   = 8;
    localparam int MODC_W   = $clog2(RAND_W);

    localparam logic [SKEW_W-1:0] SKEW_RESET = 16'd384;

    localparam logic [RULE_W-1:0] RULE_EXACT    = 2'd0;
    localparam logic [RULE_W-1:0] RULE_WEIGHTED = 2'd1;
    localparam logic [RULE_W-1:0] RULE_LEAST    = 2'd2;

    typedef struct packed {
        logic [SCORE_W-1:0]  hit_score;
        logic [WEIGHT_W-1:0] node_weight;
        logic [SCORE_W-1:0]  match_target;
        logic [RAND_W-1:0]   rand_match;
        logic [RAND_W-1:0]   rand_weighted;
        logic [RAND_W-1:0]   rand_least;
        logic                last_node;
    } in_item_t;

    typedef struct packed {
        logic [CHOICE_W-1:0] chosen_node;
        logic [RULE_W-1:0]   rule_used;
    } out_item_t;

    typedef enum logic [1:0] {
        MUL_SKEW,
        MUL_WN,
        MUL_PA,
        MUL_PB
    } mul_sel_t;

    typedef enum logic [1:0] {
        SCAN_MATCH,
        SCAN_WEIGHTED,
        SCAN_LEAST
    } scan_sel_t;

    typedef struct packed {
        logic      store;
        logic      mod_step;
        logic      scan_init;
        scan_sel_t scan_sel;
        logic      scan_next;
        mul_sel_t  mul_sel;
        logic      skew_cap;
        logic      den_cap;
        logic      pa_cap;
        logic      t0_eval;
        logic      t1_upd;
        logic      t1_pick;
        logic      t2_eval;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic last_node;
        logic mod_last;
        logic scan_last;
        logic match;
        logic have;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> sv/weighted_node_choice.sv
// Top level of the weighted node choice block: controller plus datapath.
// Depends on wnc_pkg, wnc_ctrl and wnc_dpath.
//
// Usage: each input item carries one candidate node (hit score and weight).
// Items are taken one per cycle while the block is loading. The item with
// last_node set closes the set; its match target and three random starts are
// used for the decision, and exactly one result item follows for that set.
// Nodes beyond NODES are dropped, but a last mark on such an item still closes
// the set.
// After the last item the bit-serial modulo unit runs first. Then come the
// exact-match tier, the load-weighted tier (one shared multiplier is reused
// three times per node, plus once per set for the skew product) and the
// least-loaded tier; each tier scans the nodes and runs only when the tiers
// before it gave no choice.
// Input ready is low from the last item until the result is in the output
// register. A result waiting on a stalled receiver holds the next set's
// loading open, and a further decision waits until the output register frees.
// Reset clears the node count, the weight total and the output valid, and
// sets skew_threshold to 1.5 (Q8.8 value 384). cfg_wr_en writes the
// threshold in the same cycle and must only be used while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module weighted_node_choice
    import wnc_pkg::*;
#(
    parameter int NODES = 8
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic [SKEW_W-1:0] cfg_wr_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    // Command and status bundles between the sequencer and the datapath.
    cmd_t    cmd;
    status_t status;

    wnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wnc_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_item),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_item    (out_item)
    );

endmodule

`default_nettype wire

>>> sv/wnc_dpath.sv
// Datapath of the weighted node choice block: node stores, running totals,
// modulo unit, shared multiplier, scan registers and the result register.
// Depends on wnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wnc_dpath
    import wnc_pkg::*;
#(
    parameter int NODES = 8
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic [SKEW_W-1:0] cfg_wr_data,
    input  wire in_item_t  in_item,
    input  wire cmd_t      cmd,
    output status_t        status,
    input  wire logic      out_ready,
    output logic           out_valid,
    output out_item_t      out_item
);

    localparam int IDX_W  = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int REM_W  = CNT_W + 1;
    localparam int TOT_W  = WEIGHT_W + IDX_W;
    localparam int WN_W   = WEIGHT_W + CNT_W;
    localparam int PROD_W = WN_W + SCORE_W;

    logic [SCORE_W-1:0]  score_mem [NODES];
    logic [WEIGHT_W-1:0] weight_mem [NODES];
    logic [SCORE_W-1:0]  rd_score_reg;
    logic [WEIGHT_W-1:0] rd_weight_reg;

    logic [SKEW_W-1:0] skew_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [SCORE_W-1:0] target_reg;

    logic [RAND_W-1:0] div_reg [3];
    logic [REM_W-1:0]  rem_reg [3];
    logic [REM_W-1:0]  rem_next [3];
    logic [MODC_W-1:0] modc_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] idx_wrap;
    logic [IDX_W-1:0] start_sel;

    logic [WN_W-1:0]    op_a;
    logic [SCORE_W-1:0] op_b;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  skew_tot_reg;
    logic [PROD_W-1:0]  pa_reg;
    logic [WN_W-1:0]    wn;
    logic [WN_W-1:0]    d_reg;
    logic               elig_reg;

    logic [SCORE_W-1:0] best_s_reg;
    logic [WN_W-1:0]    best_d_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               have_reg;
    logic               take;

    logic [WEIGHT_W-1:0] bw_reg;
    logic [IDX_W-1:0]    choice_reg;
    logic [RULE_W-1:0]   rule_reg;
    logic                room;
    logic                match;

    assign room = (count_reg < CNT_W'(NODES));

    // Node stores: written in load order, read at the scan index.
    always_ff @(posedge clk)
    begin
        if (cmd.store && room)
        begin
            score_mem[count_reg[IDX_W-1:0]]  <= in_item.hit_score;
            weight_mem[count_reg[IDX_W-1:0]] <= in_item.node_weight;
        end
        rd_score_reg  <= score_mem[idx_reg];
        rd_weight_reg <= weight_mem[idx_reg];
    end

    // Restoring remainder, one dividend bit per cycle in three lanes.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [REM_W-1:0] sh;
            sh = {rem_reg[k][REM_W-2:0], div_reg[k][RAND_W-1]};
            rem_next[k] = (sh >= REM_W'(count_reg)) ? sh - REM_W'(count_reg) : sh;
        end
    end

    always_comb
    begin
        case (cmd.scan_sel)
            SCAN_MATCH:    start_sel = rem_reg[0][IDX_W-1:0];
            SCAN_WEIGHTED: start_sel = rem_reg[1][IDX_W-1:0];
            SCAN_LEAST:    start_sel = rem_reg[2][IDX_W-1:0];
            default:       start_sel = rem_reg[2][IDX_W-1:0];
        endcase
    end

    assign idx_wrap = (CNT_W'(idx_reg) + CNT_W'(1) == count_reg) ? '0 : idx_reg + IDX_W'(1);

    // One shared multiplier, operands chosen by the controller.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SKEW:
            begin
                op_a = WN_W'(total_reg);
                op_b = SCORE_W'(skew_reg);
            end
            MUL_WN:
            begin
                op_a = WN_W'(rd_weight_reg);
                op_b = SCORE_W'(count_reg);
            end
            MUL_PA:
            begin
                op_a = best_d_reg;
                op_b = rd_score_reg;
            end
            MUL_PB:
            begin
                op_a = d_reg;
                op_b = best_s_reg;
            end
            default:
            begin
                op_a = d_reg;
                op_b = best_s_reg;
            end
        endcase
    end

    assign wn    = WN_W'(prod_reg);
    assign match = (rd_score_reg == target_reg);
    // An eligible candidate replaces the best if score*best_den > best_score*den.
    assign take  = elig_reg && (have_reg ? (pa_reg > prod_reg) : (rd_score_reg != '0));

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        if (cmd.skew_cap)
        begin
            skew_tot_reg <= prod_reg;
        end
        if (cmd.den_cap)
        begin
            d_reg    <= (wn > WN_W'(total_reg)) ? wn : WN_W'(total_reg);
            elig_reg <= (total_reg != '0) && (skew_tot_reg > (PROD_W'(wn) << Q_FRAC));
        end
        if (cmd.pa_cap)
        begin
            pa_reg <= prod_reg;
        end
        if (cmd.store && in_item.last_node)
        begin
            target_reg <= in_item.match_target;
        end
        if (cmd.t1_upd && take)
        begin
            best_s_reg   <= rd_score_reg;
            best_d_reg   <= d_reg;
            best_idx_reg <= idx_reg;
        end
        if (cmd.t0_eval && match)
        begin
            choice_reg <= idx_reg;
            rule_reg   <= RULE_EXACT;
        end
        if (cmd.t1_pick)
        begin
            choice_reg <= best_idx_reg;
            rule_reg   <= RULE_WEIGHTED;
        end
        if (cmd.t2_eval && ((j_reg == '0) || (rd_weight_reg < bw_reg)))
        begin
            bw_reg     <= rd_weight_reg;
            choice_reg <= idx_reg;
            rule_reg   <= RULE_LEAST;
        end
        if (cmd.out_load)
        begin
            out_item.chosen_node <= CHOICE_W'(choice_reg);
            out_item.rule_used   <= rule_reg;
        end
        if (cmd.store)
        begin
            div_reg[0] <= in_item.rand_match;
            div_reg[1] <= in_item.rand_weighted;
            div_reg[2] <= in_item.rand_least;
        end
        else if (cmd.mod_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                div_reg[k] <= div_reg[k] << 1;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (cmd.store)
            begin
                rem_reg[k] <= '0;
            end
            else if (cmd.mod_step)
            begin
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skew_reg  <= SKEW_RESET;
            count_reg <= '0;
            total_reg <= '0;
            modc_reg  <= '0;
            idx_reg   <= '0;
            j_reg     <= '0;
            have_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                skew_reg <= cfg_wr_data;
            end
            if (cmd.out_load)
            begin
                count_reg <= '0;
                total_reg <= '0;
            end
            else if (cmd.store && room)
            begin
                count_reg <= count_reg + CNT_W'(1);
                total_reg <= total_reg + TOT_W'(in_item.node_weight);
            end
            if (cmd.store)
            begin
                modc_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                modc_reg <= modc_reg + MODC_W'(1);
            end
            if (cmd.scan_init)
            begin
                idx_reg  <= start_sel;
                j_reg    <= '0;
                have_reg <= 1'b0;
            end
            else if (cmd.scan_next)
            begin
                idx_reg <= idx_wrap;
                j_reg   <= j_reg + IDX_W'(1);
            end
            if (cmd.t1_upd && take)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.last_node = in_item.last_node;
        status.mod_last  = (modc_reg == MODC_W'(RAND_W - 1));
        status.scan_last = (CNT_W'(j_reg) + CNT_W'(1) == count_reg);
        status.match     = match;
        status.have      = have_reg;
        status.out_free  = !out_valid || out_ready;
    end

endmodule

`default_nettype wire

>>> sv/wnc_ctrl.sv
// Controller of the weighted node choice block: sequences loading, the
// modulo unit and the three scans. Depends on wnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wnc_ctrl
    import wnc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_T0_INIT,
        S_T0_RD,
        S_T0_EV,
        S_T1_PRE,
        S_T1_CAP,
        S_T1_RD,
        S_T1_MW,
        S_T1_DEN,
        S_T1_PA,
        S_T1_PB,
        S_T1_UPD,
        S_T1_END,
        S_T2_RD,
        S_T2_EV
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.scan_sel = SCAN_MATCH;
        cmd.mul_sel  = MUL_WN;
        in_ready   = (state_reg == S_IDLE) && !done_reg;

        if (done_reg)
        begin
            // Decision made; wait for the result register to be free.
            if (status.out_free)
            begin
                cmd.out_load = 1'b1;
                done_next    = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.store = 1'b1;
                        if (status.last_node)
                        begin
                            state_next = S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    cmd.mod_step = 1'b1;
                    if (status.mod_last)
                    begin
                        state_next = S_T0_INIT;
                    end
                end
                S_T0_INIT:
                begin
                    cmd.scan_init = 1'b1;
                    cmd.scan_sel  = SCAN_MATCH;
                    state_next    = S_T0_RD;
                end
                S_T0_RD:
                begin
                    state_next = S_T0_EV;
                end
                S_T0_EV:
                begin
                    cmd.t0_eval = 1'b1;
                    if (status.match)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    else if (status.scan_last)
                    begin
                        cmd.scan_init = 1'b1;
                        cmd.scan_sel  = SCAN_WEIGHTED;
                        state_next    = S_T1_PRE;
                    end
                    else
                    begin
                        cmd.scan_next = 1'b1;
                        state_next    = S_T0_RD;
                    end
                end
                S_T1_PRE:
                begin
                    cmd.mul_sel = MUL_SKEW;
                    state_next  = S_T1_CAP;
                end
                S_T1_CAP:
                begin
                    cmd.skew_cap = 1'b1;
                    state_next   = S_T1_RD;
                end
                S_T1_RD:
                begin
                    state_next = S_T1_MW;
                end
                S_T1_MW:
                begin
                    cmd.mul_sel = MUL_WN;
                    state_next  = S_T1_DEN;
                end
                S_T1_DEN:
                begin
                    cmd.den_cap = 1'b1;
                    state_next  = S_T1_PA;
                end
                S_T1_PA:
                begin
                    cmd.mul_sel = MUL_PA;
                    state_next  = S_T1_PB;
                end
                S_T1_PB:
                begin
                    cmd.pa_cap  = 1'b1;
                    cmd.mul_sel = MUL_PB;
                    state_next  = S_T1_UPD;
                end
                S_T1_UPD:
                begin
                    cmd.t1_upd = 1'b1;
                    if (status.scan_last)
                    begin
                        state_next = S_T1_END;
                    end
                    else
                    begin
                        cmd.scan_next = 1'b1;
                        state_next    = S_T1_RD;
                    end
                end
                S_T1_END:
                begin
                    if (status.have)
                    begin
                        cmd.t1_pick = 1'b1;
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        cmd.scan_sel  = SCAN_LEAST;
                        state_next    = S_T2_RD;
                    end
                end
                S_T2_RD:
                begin
                    state_next = S_T2_EV;
                end
                S_T2_EV:
                begin
                    cmd.t2_eval = 1'b1;
                    if (status.scan_last)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_next = 1'b1;
                        state_next    = S_T2_RD;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire
